>>> rtl/pus_pkg.sv
// Package for the pixel unpremultiply/scale block: constants, types and the divider step.
`default_nettype none
package pus_pkg;

   localparam int CH_W          = 16;   // width of one color channel
   localparam int NUM_CH        = 3;    // red, green, blue
   localparam int FRAC_BITS_DEF = 8;    // fraction bits of the result
   localparam int FULL_LEVEL    = 255;
   localparam int OUT_MAX       = 65535;
   localparam logic [CH_W-1:0] SCALE_DIV = 16'd32767;

   localparam int CSR_ADDR_W = 3;
   localparam logic [CSR_ADDR_W-1:0] REG_CONVERT_MODE = 3'd0;

   typedef enum logic {
      MODE_SCALE    = 1'b0,
      MODE_UNPREMUL = 1'b1
   } convert_mode_type;

   // Per-channel state of the long division as it walks down the pipe.
   typedef struct packed {
      logic [CH_W-1:0] rem;   // partial remainder, below the divisor unless ovf is set
      logic [CH_W-1:0] low;   // dividend bits not yet brought down, MSB next
      logic [CH_W-1:0] quo;   // quotient bits developed so far
      logic            ovf;   // quotient does not fit in CH_W bits
   } chan_div_type;

   typedef struct packed {
      logic [CH_W-1:0]                 dvs;   // divisor: alpha or the scale constant
      logic [CH_W-1:0]                 cap;   // saturation level for this mode
      logic                            zero;  // alpha zero in unpremultiply mode
      chan_div_type [NUM_CH-1:0]       ch;
   } stage_type;

   // One restoring division step: bring down a bit, try a subtract.
   function automatic chan_div_type div_step(input chan_div_type cur,
                                             input logic [CH_W-1:0] dvs);
      logic [CH_W:0] t;
      chan_div_type  nxt;
      t        = {cur.rem, cur.low[CH_W-1]};
      nxt      = cur;
      nxt.low  = {cur.low[CH_W-2:0], 1'b0};
      if (t >= {1'b0, dvs}) begin
         nxt.rem = CH_W'(t - {1'b0, dvs});
         nxt.quo = {cur.quo[CH_W-2:0], 1'b1};
      end else begin
         nxt.rem = t[CH_W-1:0];
         nxt.quo = {cur.quo[CH_W-2:0], 1'b0};
      end
      return nxt;
   endfunction

endpackage
`default_nettype wire

>>> rtl/pixel_unpremultiply_scale.sv
// Top level: per-pixel scale or alpha unpremultiply to unsigned fixed point.
//
// Input stream req_*: one pixel per transfer, R, G, B, A in 16-bit host range.
// Result stream rsp_*: R, G, B as unsigned fixed point with FRAC_BITS fraction bits.
// CSR port (APB style, pready tied high): register convert_mode at address 0,
// 0 scales each channel by 255/32767, 1 divides by alpha and clamps at 255.0.
// Alpha zero in unpremultiply mode gives black.
//
// Pipeline: a result passes the input register, the divider setup stage, 16 divider
// stages and the output register before it shows on rsp_tvalid. Throughput is
// one pixel per cycle while the skid register is empty; each of the 16 divider
// stages develops one quotient bit for all three channels.
//
// Reset clears every valid bit and sets convert_mode to scale.
// When the receiver stalls, one result parks in a skid register behind the
// output register; req_tready then drops and the whole pipe holds until the
// output drains. Nothing is lost or repeated.
`default_nettype none
module pixel_unpremultiply_scale #(
   parameter int FRAC_BITS = pus_pkg::FRAC_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   // input stream; tdata from bit 0: red_in, green_in, blue_in, alpha_in
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [4*pus_pkg::CH_W-1:0]      req_tdata,
   // result stream; tdata from bit 0: red_out, green_out, blue_out
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [3*pus_pkg::CH_W-1:0]      rsp_tdata,
   // configuration port
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [pus_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [31:0]                     csr_pwdata,
   output logic [31:0]                     csr_prdata,
   output logic                            csr_pready
);
   import pus_pkg::*;

   localparam int NUM_W     = CH_W + 8 + FRAC_BITS;   // c * 255 << FRAC_BITS
   localparam int HI_W      = NUM_W - CH_W;           // dividend bits above the quotient
   localparam int CW        = (HI_W > CH_W) ? HI_W : CH_W;
   localparam int TOP       = FULL_LEVEL << FRAC_BITS;
   localparam int CAP_UNPM  = (TOP > OUT_MAX) ? OUT_MAX : TOP;
   localparam int DIV_STEPS = CH_W;
   localparam logic [CH_W-1:0] CAP_UNPM_V = CH_W'(CAP_UNPM);
   localparam logic [CH_W-1:0] CAP_SCALE_V = CH_W'(OUT_MAX);

   // ---------------------------------------------------------------- CSR
   convert_mode_type convert_mode_ff;
   logic             csr_write;
   logic             csr_hit_mode;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   // decode on the word address; the two byte-lane bits do not select a register
   assign csr_hit_mode = (csr_paddr[CSR_ADDR_W-1:2] == REG_CONVERT_MODE[CSR_ADDR_W-1:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         convert_mode_ff <= MODE_SCALE;
      end else if (csr_write && csr_hit_mode) begin
         convert_mode_ff <= convert_mode_type'(csr_pwdata[0]);
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_hit_mode) begin
         csr_prdata = 32'(convert_mode_ff);
      end
   end

   // ------------------------------------------------------ flow control
   // The pipe advances as one; it holds only while the skid register is full.
   logic advance;
   logic emit;
   logic skid_valid_ff;
   logic rsp_tvalid_ff;
   logic [3*CH_W-1:0] skid_data_ff;
   logic [3*CH_W-1:0] rsp_tdata_ff;

   assign advance    = !skid_valid_ff;
   assign req_tready = advance;

   // ------------------------------------------------ stage 1: input register
   // Form the dividend c * 255 << FRAC_BITS and pick divisor and cap by mode.
   logic                  s1_vld_ff;
   logic [NUM_W-1:0]      s1_num_ff [NUM_CH];
   logic [NUM_W-1:0]      s1_num_in [NUM_CH];
   logic [CH_W-1:0]       s1_dvs_ff, s1_dvs_in;
   logic [CH_W-1:0]       s1_cap_ff, s1_cap_in;
   logic                  s1_zero_ff, s1_zero_in;
   logic [CH_W-1:0]       alpha;

   assign alpha = req_tdata[3*CH_W +: CH_W];

   always_comb begin
      logic [CH_W-1:0]   c;
      logic [CH_W+7:0]   prod;
      for (int i = 0; i < NUM_CH; i++) begin
         c            = req_tdata[i*CH_W +: CH_W];
         prod         = {c, 8'b0} - {8'b0, c};
         s1_num_in[i] = NUM_W'(prod) << FRAC_BITS;
      end
      if (convert_mode_ff == MODE_UNPREMUL) begin
         s1_dvs_in  = alpha;
         s1_cap_in  = CAP_UNPM_V;
         s1_zero_in = (alpha == '0);
      end else begin
         s1_dvs_in  = SCALE_DIV;
         s1_cap_in  = CAP_SCALE_V;
         s1_zero_in = 1'b0;
      end
   end

   // ------------------------------------------- divider setup and 16 steps
   // Stage 0 checks for quotient overflow and loads the top remainder;
   // each later stage develops one quotient bit.
   stage_type              pipe_ff [DIV_STEPS+1];
   stage_type              pipe_in [DIV_STEPS+1];
   logic [DIV_STEPS:0]     pvld_ff;

   always_comb begin
      logic [HI_W-1:0] num_hi;
      pipe_in[0].dvs  = s1_dvs_ff;
      pipe_in[0].cap  = s1_cap_ff;
      pipe_in[0].zero = s1_zero_ff;
      for (int i = 0; i < NUM_CH; i++) begin
         num_hi                 = s1_num_ff[i][NUM_W-1:CH_W];
         pipe_in[0].ch[i].ovf   = (CW'(num_hi) >= CW'(s1_dvs_ff));
         pipe_in[0].ch[i].rem   = CH_W'(num_hi);
         pipe_in[0].ch[i].low   = s1_num_ff[i][CH_W-1:0];
         pipe_in[0].ch[i].quo   = '0;
      end
      for (int k = 0; k < DIV_STEPS; k++) begin
         pipe_in[k+1] = pipe_ff[k];
         for (int i = 0; i < NUM_CH; i++) begin
            pipe_in[k+1].ch[i] = div_step(pipe_ff[k].ch[i], pipe_ff[k].dvs);
         end
      end
   end

   // ------------------------------------------------- saturate and pack
   logic [3*CH_W-1:0] res_pack;

   always_comb begin
      stage_type last;
      last = pipe_ff[DIV_STEPS];
      for (int i = 0; i < NUM_CH; i++) begin
         if (last.zero) begin
            res_pack[i*CH_W +: CH_W] = '0;
         end else if (last.ch[i].ovf || last.ch[i].quo > last.cap) begin
            res_pack[i*CH_W +: CH_W] = last.cap;
         end else begin
            res_pack[i*CH_W +: CH_W] = last.ch[i].quo;
         end
      end
   end

   assign emit = advance && pvld_ff[DIV_STEPS];

   // ------------------------------------------------------ control regs
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff     <= 1'b0;
         pvld_ff       <= '0;
         rsp_tvalid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (advance) begin
            s1_vld_ff <= req_tvalid;
            pvld_ff   <= {pvld_ff[DIV_STEPS-1:0], s1_vld_ff};
         end
         if (!rsp_tvalid_ff || rsp_tready) begin
            // output free: drain skid first, else take the pipe's result
            rsp_tvalid_ff <= skid_valid_ff || emit;
            skid_valid_ff <= 1'b0;
         end else if (emit) begin
            // output stalled: park the result
            skid_valid_ff <= 1'b1;
         end
      end
   end

   // --------------------------------------------------------- data regs
   always_ff @(posedge clock) begin
      if (advance) begin
         for (int i = 0; i < NUM_CH; i++) begin
            s1_num_ff[i] <= s1_num_in[i];
         end
         s1_dvs_ff  <= s1_dvs_in;
         s1_cap_ff  <= s1_cap_in;
         s1_zero_ff <= s1_zero_in;
         for (int k = 0; k <= DIV_STEPS; k++) begin
            pipe_ff[k] <= pipe_in[k];
         end
      end
      if (!rsp_tvalid_ff || rsp_tready) begin
         rsp_tdata_ff <= skid_valid_ff ? skid_data_ff : res_pack;
      end else if (emit) begin
         skid_data_ff <= res_pack;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   // -------------------------------------------------------- assertions
   a_skid_behind_output : assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_tvalid_ff)
      else $error("skid register holds a result while the output is empty");

   a_stall_parks_result : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid_ff && !rsp_tready && advance && pvld_ff[DIV_STEPS])
         |=> (skid_valid_ff && !req_tready))
      else $error("stalled result was not parked or intake did not stop");

   a_mode_only_by_write : assert property (@(posedge clock) disable iff (reset)
      !csr_write |=> $stable(convert_mode_ff))
      else $error("convert_mode changed without a register write");

endmodule
`default_nettype wire

>>> test/pixel_unpremultiply_scale_tb.sv
// Testbench for pixel_unpremultiply_scale: stream driver, result checker and mode sweeps.
`timescale 1ns / 1ps
module pixel_unpremultiply_scale_tb;
   import pus_pkg::*;

   localparam int FRAC_BITS      = FRAC_BITS_DEF;
   localparam int PIPE_LATENCY   = 18;     // input transfer to rsp_tvalid, no stall
   localparam int HOLD_CYCLES    = 300;    // long receiver hold-off, well past pipe depth
   localparam int WATCHDOG_LIMIT = 2000;   // cycles without any transfer
   localparam int REPORT_LIMIT   = 10;

   // Packed so that the last field (red) lands in the lowest bits of tdata.
   typedef struct packed {
      logic [CH_W-1:0] alpha;
      logic [CH_W-1:0] blue;
      logic [CH_W-1:0] green;
      logic [CH_W-1:0] red;
   } pixel_type;

   typedef struct packed {
      logic [CH_W-1:0] blue;
      logic [CH_W-1:0] green;
      logic [CH_W-1:0] red;
   } color_type;

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_tvalid  = 1'b0;
   logic                  req_tready;
   logic [4*CH_W-1:0]     req_tdata   = '0;   // red_in, green_in, blue_in, alpha_in
   logic                  rsp_tvalid;
   logic                  rsp_tready  = 1'b0;
   logic [3*CH_W-1:0]     rsp_tdata;          // red_out, green_out, blue_out
   logic                  csr_psel    = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [31:0]           csr_pwdata  = '0;
   logic [31:0]           csr_prdata;
   logic                  csr_pready;

   pixel_type        pending_pixels[$];    // waiting to be offered on req_*
   color_type        expected_colors[$];   // predicted results, oldest first
   convert_mode_type active_mode  = MODE_SCALE;
   int unsigned      src_gap_max  = 7;
   int unsigned      snk_gap_max  = 7;
   int unsigned      src_wait     = 0;
   int unsigned      snk_wait     = 0;
   int unsigned      hold_serial  = 0;    // bumped to ask the receiver for a long hold
   int unsigned      hold_taken   = 0;
   int unsigned      error_count  = 0;
   int unsigned      stall_cycles = 0;

   pixel_unpremultiply_scale #(
      .FRAC_BITS(FRAC_BITS)
   ) i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Exact rational quotient, truncated. Scale mode divides by 32767 with no clamp;
   // unpremultiply divides by alpha and clamps at 255.0, alpha zero gives black.
   // Anything past 16 bits saturates in both modes.
   function automatic logic [CH_W-1:0] convert_channel(logic [CH_W-1:0] chan,
                                                       logic [CH_W-1:0] alpha,
                                                       convert_mode_type mode);
      logic [63:0] num;
      logic [63:0] quo;
      num = (64'(chan) * 64'(FULL_LEVEL)) << FRAC_BITS;
      if (mode == MODE_SCALE) begin
         quo = num / 64'(SCALE_DIV);
      end else if (alpha == '0) begin
         quo = '0;
      end else begin
         quo = num / 64'(alpha);
         if (quo > (64'(FULL_LEVEL) << FRAC_BITS)) begin
            quo = 64'(FULL_LEVEL) << FRAC_BITS;
         end
      end
      if (quo > 64'(OUT_MAX)) begin
         quo = 64'(OUT_MAX);
      end
      return quo[CH_W-1:0];
   endfunction

   function automatic color_type predict_color(pixel_type pix, convert_mode_type mode);
      color_type col;
      col.red   = convert_channel(pix.red,   pix.alpha, mode);
      col.green = convert_channel(pix.green, pix.alpha, mode);
      col.blue  = convert_channel(pix.blue,  pix.alpha, mode);
      return col;
   endfunction

   // Mostly nominal range; one channel in ten uses the full 16 bits.
   function automatic logic [CH_W-1:0] random_channel(int unsigned top);
      if ($urandom_range(0, 9) == 0) begin
         return CH_W'($urandom());
      end
      return CH_W'($urandom_range(0, top));
   endfunction

   // In unpremultiply mode most pixels are well formed (color at or below alpha);
   // the rest are zero alpha, full-range alpha or colors above alpha.
   function automatic pixel_type random_pixel(convert_mode_type mode);
      pixel_type   pix;
      int unsigned pick;
      int unsigned top;
      pick      = $urandom_range(0, 99);
      pix.alpha = CH_W'($urandom_range(1, 32768));
      if (pick < 5) begin
         pix.alpha = '0;
      end else if (pick < 10) begin
         pix.alpha = CH_W'($urandom());
      end
      top = (mode == MODE_UNPREMUL && pick >= 10 && pick < 85) ? pix.alpha : 32768;
      pix.red   = random_channel(top);
      pix.green = random_channel(top);
      pix.blue  = random_channel(top);
      return pix;
   endfunction

   // Driver: keep the current pixel on req_tdata until the transfer, then draw a gap.
   always @(posedge clock) begin : drive_pixels
      logic offer;
      if (reset) begin
         req_tvalid <= 1'b0;
         src_wait = 0;
      end else begin
         offer = req_tvalid;
         if (req_tvalid && req_tready) begin
            expected_colors.push_back(predict_color(req_tdata, active_mode));
            offer    = 1'b0;
            src_wait = $urandom_range(0, src_gap_max);
         end
         if (!offer) begin
            if (src_wait > 0) begin
               src_wait--;
            end else if (pending_pixels.size() != 0) begin
               req_tdata <= pending_pixels.pop_front();
               offer = 1'b1;
            end
         end
         req_tvalid <= offer;
      end
   end

   // Monitor: check each result transfer against the oldest prediction, then stall
   // rsp_tready for a drawn number of cycles, or for a long hold when one is asked.
   always @(posedge clock) begin : check_colors
      logic             take;
      logic [2:0][15:0] want;
      logic [2:0][15:0] got;
      string            chan_name[3];
      chan_name = '{"red", "green", "blue"};
      if (reset) begin
         rsp_tready <= 1'b0;
         snk_wait = 0;
      end else begin
         take = rsp_tready;
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            if (expected_colors.size() == 0) begin
               error_count++;
               if (error_count <= REPORT_LIMIT) begin
                  $display("%0t: result %h with nothing expected", $realtime, rsp_tdata);
               end
            end else begin
               want = expected_colors.pop_front();
               for (int k = 0; k < NUM_CH; k++) begin
                  if (got[k] !== want[k]) begin
                     error_count++;
                     if (error_count <= REPORT_LIMIT) begin
                        $display("%0t: %s mismatch, expected %h, actual %h",
                                 $realtime, chan_name[k], want[k], got[k]);
                     end
                  end
               end
            end
            if (hold_serial != hold_taken) begin
               hold_taken = hold_serial;
               snk_wait   = HOLD_CYCLES;
            end else begin
               snk_wait = $urandom_range(0, snk_gap_max);
            end
            if (snk_wait > 0) begin
               take = 1'b0;
            end
         end else if (!rsp_tready) begin
            if (snk_wait > 0) begin
               snk_wait--;
            end
            if (snk_wait == 0) begin
               take = 1'b1;
            end
         end
         rsp_tready <= take;
      end
   end

   // Watchdog: any transfer or register access restarts the count.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_psel) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no transfer for %0d cycles", stall_cycles);
         $display("Simulation FAILED");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // Setup cycle, access cycle; the register takes the value at the access edge.
   task automatic csr_write(logic [31:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= REG_CONVERT_MODE;
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      active_mode = convert_mode_type'(value[0]);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // Sample on the falling edge so every posedge update has settled.
   task automatic wait_drained();
      while (pending_pixels.size() != 0 || req_tvalid || expected_colors.size() != 0) begin
         @(negedge clock);
      end
   endtask

   task automatic add_pixel(logic [CH_W-1:0] red, logic [CH_W-1:0] green,
                            logic [CH_W-1:0] blue, logic [CH_W-1:0] alpha);
      pending_pixels.push_back('{alpha: alpha, blue: blue, green: green, red: red});
   endtask

   task automatic run_random_phase(logic [31:0] mode_word, int unsigned count,
                                   int unsigned src_max, int unsigned snk_max,
                                   bit long_hold);
      csr_write(mode_word);
      src_gap_max = src_max;
      snk_gap_max = snk_max;
      if (long_hold) begin
         hold_serial++;
      end
      for (int unsigned n = 0; n < count; n++) begin
         pending_pixels.push_back(random_pixel(active_mode));
      end
      wait_drained();
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Scale mode straight out of reset: range ends, above-range channels
      // that saturate, and alpha that must be ignored.
      add_pixel(16'd0,     16'd0,     16'd0,     16'd0);
      add_pixel(16'd32768, 16'd32767, 16'd1,     16'd0);
      add_pixel(16'd65535, 16'd32769, 16'd40000, 16'd32768);
      add_pixel(16'hFFFF,  16'h0001,  16'h7FFF,  16'hFFFF);
      add_pixel(16'd128,   16'd256,   16'd16384, 16'd12345);
      wait_drained();

      // Unpremultiply: zero alpha, color equal to alpha, color above alpha
      // (clamp), smallest and largest alpha, full 16-bit values.
      csr_write({31'd0, MODE_UNPREMUL});
      add_pixel(16'd100,   16'd32768, 16'd65535, 16'd0);
      add_pixel(16'd1000,  16'd1000,  16'd1000,  16'd1000);
      add_pixel(16'd2000,  16'd65535, 16'd1001,  16'd1000);
      add_pixel(16'd1,     16'd0,     16'd32768, 16'd32768);
      add_pixel(16'd0,     16'd1,     16'd65535, 16'd1);
      add_pixel(16'd65535, 16'd32768, 16'd1,     16'd65535);
      add_pixel(16'd32768, 16'd16384, 16'd0,     16'd32768);
      add_pixel(16'd255,   16'd128,   16'd77,    16'd256);
      add_pixel(16'd0,     16'd0,     16'd0,     16'd0);
      add_pixel(16'd32767, 16'd32766, 16'd12345, 16'd32767);
      wait_drained();

      // Random phases across both modes and a range of idle patterns.
      run_random_phase({31'd0, MODE_SCALE},    200, 7, 7, 1'b0);
      run_random_phase({31'd0, MODE_UNPREMUL}, 250, 7, 7, 1'b0);
      run_random_phase({31'd0, MODE_UNPREMUL}, 200, 0, 0, 1'b0);
      // Sender at full rate while the receiver holds off: the pipe must fill and stall.
      run_random_phase({31'd0, MODE_UNPREMUL}, 200, 0, 3, 1'b1);
      run_random_phase({31'd0, MODE_SCALE},    200, 0, 7, 1'b0);
      // Upper write-data bits set: only bit 0 selects the mode.
      run_random_phase(32'hFFFF_FFFF,          250, 7, 0, 1'b0);
      run_random_phase({31'd0, MODE_SCALE},    150, 0, 2, 1'b1);
      run_random_phase({31'd0, MODE_UNPREMUL}, 180, 3, 3, 1'b0);

      wait_drained();
      repeat (PIPE_LATENCY + 4) @(posedge clock);
      if (error_count == 0 && expected_colors.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
